@@ rtl/skrs_pkg.sv @@
// Package for the sorted key range-sum table: sizes, codes and the payload
// and memory-port struct types. Depends on nothing; every rtl file imports it.
package skrs_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 27;
    localparam int AMT_W    = 32;
    localparam int SUM_W    = 48;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic [KEY_W-1:0]        key;
        logic [KEY_W-1:0]        key_high;
        logic signed [AMT_W-1:0] amount;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] range_sum;
        logic                    status;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [SUM_W-1:0] amount;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

@@ rtl/skrs_sat_add.sv @@
// Shared 48-bit signed saturating adder used for amount updates and range sums.
// Depends on skrs_pkg for the word width.
module skrs_sat_add (
    input  logic signed [skrs_pkg::SUM_W-1:0] a,
    input  logic signed [skrs_pkg::SUM_W-1:0] b,
    output logic signed [skrs_pkg::SUM_W-1:0] y
);
    import skrs_pkg::*;

    logic signed [SUM_W:0] wide_sum;

    assign wide_sum = {a[SUM_W-1], a} + {b[SUM_W-1], b};

    // The two top bits differ only when the true sum left the 48-bit range.
    always_comb begin
        if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
            y = wide_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            y = wide_sum[SUM_W-1:0];
        end
    end

endmodule

@@ rtl/skrs_store.sv @@
// Sorted entry store: one write port and one registered read port.
// Depends on skrs_pkg for the entry and request types.
module skrs_store (
    input  logic               aclk,
    input  skrs_pkg::mem_req_t req,
    output skrs_pkg::entry_t   rd_data
);
    import skrs_pkg::*;

    entry_t mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data <= mem[req.raddr];
    end

endmodule

@@ rtl/sorted_key_range_sum_table_core.sv @@
// Sorted key range-sum table, top level: sequencer, control registers, output register.
// An add goes from input transfer to valid result through scan, shift and finish; a report
// also runs its sum pass. The store is walked one entry per cycle through its single read port.
// Input ready rises with result valid, so items go one at a time; a held result stalls finish.
// Reset (aresetn low, synchronous) clears the entry count and the handshake state only.
module sorted_key_range_sum_table_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  skrs_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output skrs_pkg::out_item_t m_item
);
    import skrs_pkg::*;

    // SCAN walks upward to the first key not below the item key. An equal key is
    // updated in place; otherwise, if there is room, the new entry is written there
    // and CARRY ripples the displaced entries up one slot each. A report then rereads
    // from that slot in SUM and accumulates while keys stay at or below the high key.
    typedef enum logic [2:0] {
        IDLE,
        SCAN,
        CARRY,
        SUM_PRIME,
        SUM,
        FINISH
    } state_t;

    state_t                  state_reg;
    in_item_t                item_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        pos_reg;
    logic [CNT_W-1:0]        count_reg;
    entry_t                  carry_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    status_reg;
    logic                    m_valid_reg;
    out_item_t               m_item_reg;

    mem_req_t                mem_req;
    entry_t                  rd_entry;
    logic signed [SUM_W-1:0] add_a;
    logic signed [SUM_W-1:0] add_b;
    logic signed [SUM_W-1:0] add_y;
    logic signed [SUM_W-1:0] new_amount;
    logic [CNT_W-1:0]        idx_plus;
    logic                    at_end;
    logic                    is_report;

    skrs_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_entry)
    );

    skrs_sat_add u_add (
        .a (add_a),
        .b (add_b),
        .y (add_y)
    );

    assign s_ready   = (state_reg == IDLE);
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign idx_plus  = idx_reg + 1'b1;
    // In SCAN, CARRY and SUM the read data belongs to the entry at idx_reg; past the count it is unused.
    assign at_end    = (idx_reg == count_reg);
    assign is_report = (item_reg.operation == OP_REPORT);

    // A report inserts its low key with amount zero.
    assign new_amount = is_report ? '0
                                  : {{(SUM_W-AMT_W){item_reg.amount[AMT_W-1]}}, item_reg.amount};

    // The one adder serves the in-place update during the scan and the range sum.
    always_comb begin
        if (state_reg == SUM) begin
            add_a = sum_reg;
            add_b = rd_entry.amount;
        end else begin
            add_a = rd_entry.amount;
            add_b = new_amount;
        end
    end

    // Memory port. The read address runs one entry ahead so that data for idx_reg
    // is ready each cycle; in IDLE it points at entry zero for the coming scan.
    always_comb begin
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg[IDX_W-1:0];
        mem_req.wdata = carry_reg;
        mem_req.raddr = idx_plus[IDX_W-1:0];
        case (state_reg)
            IDLE: begin
                mem_req.raddr = '0;
            end
            SCAN: begin
                if (!at_end && rd_entry.key == item_reg.key) begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = '{key: item_reg.key, amount: add_y};
                end else if ((at_end || rd_entry.key > item_reg.key)
                             && count_reg != CNT_W'(CAPACITY)) begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = '{key: item_reg.key, amount: new_amount};
                end
            end
            CARRY: begin
                mem_req.we = 1'b1;
            end
            SUM_PRIME: begin
                mem_req.raddr = idx_reg[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // In FINISH the load below decides the valid flag on its own.
            if (m_valid_reg && m_ready && state_reg != FINISH) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        item_reg   <= s_item;
                        idx_reg    <= '0;
                        sum_reg    <= '0;
                        status_reg <= STATUS_DONE;
                        state_reg  <= SCAN;
                    end
                end
                SCAN: begin
                    if (!at_end && rd_entry.key < item_reg.key) begin
                        idx_reg <= idx_plus;
                    end else begin
                        pos_reg <= idx_reg;
                        if (!at_end && rd_entry.key == item_reg.key) begin
                            state_reg <= is_report ? SUM_PRIME : FINISH;
                        end else if (count_reg == CNT_W'(CAPACITY)) begin
                            // Full table: nothing is inserted; a report's sum still runs.
                            status_reg <= STATUS_FULL;
                            state_reg  <= is_report ? SUM_PRIME : FINISH;
                        end else if (at_end) begin
                            count_reg <= count_reg + 1'b1;
                            state_reg <= is_report ? SUM_PRIME : FINISH;
                        end else begin
                            carry_reg <= rd_entry;
                            idx_reg   <= idx_plus;
                            state_reg <= CARRY;
                        end
                    end
                end
                CARRY: begin
                    if (at_end) begin
                        count_reg <= count_reg + 1'b1;
                        idx_reg   <= pos_reg;
                        state_reg <= is_report ? SUM_PRIME : FINISH;
                    end else begin
                        carry_reg <= rd_entry;
                        idx_reg   <= idx_plus;
                    end
                end
                SUM_PRIME: begin
                    state_reg <= SUM;
                end
                SUM: begin
                    if (at_end || rd_entry.key > item_reg.key_high) begin
                        state_reg <= FINISH;
                    end else begin
                        sum_reg <= add_y;
                        idx_reg <= idx_plus;
                    end
                end
                FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_item_reg  <= '{range_sum: sum_reg, status: status_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // The entry count never passes the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // The count grows by at most one entry per cycle and never shrinks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1))
        else $error("entry count moved by more than one");

    // Writes land only inside the table, at or below the current count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.we |-> (idx_reg < CNT_W'(CAPACITY)) && (idx_reg <= count_reg))
        else $error("store write outside the table");

    // An accepted transfer blocks the input until its result is formed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transfer");

    // A result is loaded only when the output register is free or being drained.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FINISH) && m_valid_reg && !m_ready |=> m_valid_reg
            && (state_reg == FINISH))
        else $error("result register overwritten while held");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sorted_key_range_sum_table_core. It holds its own sorted-table
// predictor and runs a directed table followed by random traffic. Needs skrs_pkg.
module tb;
    import skrs_pkg::*;

    // Idle draws, the long receiver hold-off and the run-length guards. One item costs at
    // most a scan, a shift and a sum pass over the whole store.
    localparam int MAX_GAP        = 11;
    localparam int HOLD_CYCLES    = 250;
    localparam int ITEM_LATENCY   = 2 * CAPACITY + 8;
    localparam int WATCHDOG_LIMIT = 8 * (ITEM_LATENCY + HOLD_CYCLES + 2 * MAX_GAP);
    localparam int RANDOM_ITEMS   = 550;

    localparam logic [KEY_W-1:0]        KEY_TOP  = '1;
    localparam logic [KEY_W-1:0]        DATE_TOP = 27'd99991231;
    localparam logic signed [AMT_W-1:0] AMT_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [AMT_W-1:0] AMT_MIN  = 32'sh8000_0000;
    localparam logic signed [SUM_W-1:0] SUM_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN  = 48'sh8000_0000_0000;

    // One row of the directed table. Where typed_in is set, the expected result is the
    // one written in the row; otherwise the predictor supplies it.
    typedef struct {
        logic                    operation;
        logic [KEY_W-1:0]        key;
        logic [KEY_W-1:0]        key_high;
        logic signed [AMT_W-1:0] amount;
        int                      reps;
        bit                      typed_in;
        logic signed [SUM_W-1:0] sum;
        logic                    status;
    } dir_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // Predictor state: the sorted keys, their running amounts and the entry count.
    logic [KEY_W-1:0]        tbl_key [CAPACITY];
    logic signed [SUM_W-1:0] tbl_amt [CAPACITY];
    int                      tbl_count = 0;

    // Results predicted at input transfer time, oldest first.
    out_item_t pending_outcomes [$];

    int items_sent     = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;
    int hold_at_result = -1;
    bit no_idle        = 1'b0;

    // The directed table. The repeated row is a short burst of adds to one key.
    dir_row_t dir_rows [20] = '{
        // Report on an empty table: the low key goes in with amount 0.
        '{OP_REPORT, 27'd0,        27'd0,        32'sd0,       1,        1'b1, 48'sd0,
          STATUS_DONE},
        // The largest amount on key 0 and one more on the neighboring key.
        '{OP_ADD,    27'd0,        27'd5,        AMT_MAX,      1,        1'b1, 48'sd0,
          STATUS_DONE},
        '{OP_ADD,    27'd1,        27'd0,        32'sd1,       1,        1'b1, 48'sd0,
          STATUS_DONE},
        // The sum runs past the 32-bit range of a single amount.
        '{OP_REPORT, 27'd0,        27'd1,        32'sd0,       1,        1'b1,
          48'sd2147483648, STATUS_DONE},
        '{OP_ADD,    27'd0,        KEY_TOP,      AMT_MIN,      1,        1'b1, 48'sd0,
          STATUS_DONE},
        // Key above the date range is kept as given.
        '{OP_ADD,    KEY_TOP,      27'd0,        AMT_MIN,      1,        1'b1, 48'sd0,
          STATUS_DONE},
        '{OP_REPORT, 27'd2,        KEY_TOP,      AMT_MAX,      1,        1'b1,
          -48'sd2147483648, STATUS_DONE},
        '{OP_ADD,    27'd20240115, 27'd0,        32'sd1000,    6,        1'b0, 48'sd0,
          STATUS_DONE},
        '{OP_ADD,    27'd20240115, 27'd0,        -32'sd250,    1,        1'b0, 48'sd0,
          STATUS_DONE},
        '{OP_ADD,    DATE_TOP,     27'd0,        32'sd5,       1,        1'b0, 48'sd0,
          STATUS_DONE},
        '{OP_REPORT, 27'd20240101, 27'd20241231, 32'sd0,       1,        1'b0, 48'sd0,
          STATUS_DONE},
        // Inverted ranges give 0; an absent low key is still inserted.
        '{OP_REPORT, DATE_TOP,     27'd20240101, 32'sd0,       1,        1'b1, 48'sd0,
          STATUS_DONE},
        '{OP_REPORT, 27'd30000000, 27'd10,       32'sd0,       1,        1'b1, 48'sd0,
          STATUS_DONE},
        '{OP_REPORT, 27'd20240115, 27'd20240115, 32'sd0,       1,        1'b0, 48'sd0,
          STATUS_DONE},
        '{OP_REPORT, 27'd20240116, 27'd20240116, 32'sd0,       1,        1'b0, 48'sd0,
          STATUS_DONE},
        '{OP_ADD,    27'h5555555,  27'h2AAAAAA,  32'sh55555555, 1,       1'b0, 48'sd0,
          STATUS_DONE},
        '{OP_ADD,    27'h2AAAAAA,  27'h5555555,  32'shAAAAAAAA, 1,       1'b0, 48'sd0,
          STATUS_DONE},
        '{OP_REPORT, 27'h2AAAAAA,  27'h5555555,  32'sh55555555, 1,       1'b0, 48'sd0,
          STATUS_DONE},
        '{OP_REPORT, 27'd0,        KEY_TOP,      32'sd0,       1,        1'b0, 48'sd0,
          STATUS_DONE},
        '{OP_REPORT, KEY_TOP,      KEY_TOP,      32'sd0,       1,        1'b1,
          -48'sd2147483648, STATUS_DONE}
    };

    sorted_key_range_sum_table_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Sum of two 48-bit values, clamped to the signed 48-bit range.
    function automatic logic signed [SUM_W-1:0] sat_add48(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'(SUM_MAX)) begin
            s = longint'(SUM_MAX);
        end else if (s < longint'(SUM_MIN)) begin
            s = longint'(SUM_MIN);
        end
        return s[SUM_W-1:0];
    endfunction

    // First position whose key is not below k, or the entry count.
    function automatic int lower_index(input logic [KEY_W-1:0] k);
        int i;
        i = 0;
        while (i < tbl_count && tbl_key[i] < k) i++;
        return i;
    endfunction

    // Adds v to the entry of key k, or inserts it in order. A new key that does not fit
    // leaves the table as it was and reports a full table.
    function automatic logic credit_amount(
        input logic [KEY_W-1:0]        k,
        input logic signed [SUM_W-1:0] v
    );
        int p;
        p = lower_index(k);
        if (p < tbl_count && tbl_key[p] == k) begin
            tbl_amt[p] = sat_add48(tbl_amt[p], v);
            return STATUS_DONE;
        end
        if (tbl_count >= CAPACITY) return STATUS_FULL;
        for (int j = tbl_count; j > p; j--) begin
            tbl_key[j] = tbl_key[j-1];
            tbl_amt[j] = tbl_amt[j-1];
        end
        tbl_key[p] = k;
        tbl_amt[p] = v;
        tbl_count++;
        return STATUS_DONE;
    endfunction

    // Expected result of one item; updates the predictor's table as the block would.
    function automatic out_item_t table_outcome(input in_item_t it);
        out_item_t res;
        int        i;
        res.range_sum = '0;
        if (it.operation == OP_ADD) begin
            res.status = credit_amount(it.key, {{(SUM_W-AMT_W){it.amount[AMT_W-1]}},
                                                it.amount});
        end else begin
            // A report first makes sure its low key is present, then sums upward.
            res.status = credit_amount(it.key, '0);
            i = lower_index(it.key);
            while (i < tbl_count && tbl_key[i] <= it.key_high) begin
                res.range_sum = sat_add48(res.range_sum, tbl_amt[i]);
                i++;
            end
        end
        return res;
    endfunction

    // Random item. Keys lean toward ones already stored and their neighbors so that
    // adds land on existing entries and the table grows slowly; the rest are corner
    // values, date-like values and full 27-bit noise.
    function automatic in_item_t random_item();
        in_item_t         it;
        logic [KEY_W-1:0] k;
        int               r;
        it.operation = $urandom_range(0, 1) ? OP_REPORT : OP_ADD;
        it.key_high  = KEY_W'($urandom);
        it.amount    = $urandom;
        r = $urandom_range(0, 19);
        if (tbl_count > 0 && r < 9) begin
            k = tbl_key[$urandom_range(0, tbl_count - 1)];
        end else if (tbl_count > 0 && r < 12) begin
            k = tbl_key[$urandom_range(0, tbl_count - 1)];
            k = $urandom_range(0, 1) ? k + 1'b1 : k - 1'b1;
        end else if (r < 15) begin
            case ($urandom_range(0, 3))
                0: k = '0;
                1: k = DATE_TOP;
                2: k = DATE_TOP + 1'b1;
                default: k = KEY_TOP;
            endcase
        end else if (r < 17) begin
            k = KEY_W'($urandom_range(19000101, 21001231));
        end else begin
            k = KEY_W'($urandom);
        end
        it.key = k;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            it.amount = AMT_MIN;
        end else if (r == 1) begin
            it.amount = AMT_MAX;
        end else if (r < 8) begin
            it.amount = $urandom_range(0, 2000) - 1000;
        end
        if (it.operation == OP_REPORT) begin
            r = $urandom_range(0, 19);
            if (r < 10) begin
                it.key_high = k + KEY_W'($urandom_range(0, 1 << $urandom_range(0, 26)));
            end else if (r < 14 && tbl_count > 0) begin
                it.key_high = tbl_key[$urandom_range(0, tbl_count - 1)];
            end else if (r < 17) begin
                it.key_high = k - KEY_W'($urandom_range(1, 1000));
            end
        end
        return it;
    endfunction

    // Offers one item on the input channel, starting and ending at a falling edge.
    // The predicted result is queued at the rising edge that completes the transfer.
    // Valid is lowered only when an idle gap is drawn, so back-to-back items keep it
    // high with just the payload changing.
    task automatic offer_item(
        input in_item_t  it,
        input bit        use_fixed,
        input out_item_t fixed_out
    );
        int        gap;
        out_item_t outcome;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        outcome = table_outcome(it);
        if (use_fixed) begin
            outcome = fixed_out;
        end
        pending_outcomes = {pending_outcomes, outcome};
        items_sent++;
        @(negedge aclk);
    endtask

    // Stimulus: reset, directed table, random traffic with one drain pause, and finally
    // the end of the run.
    initial begin : stimulus
        in_item_t  it;
        out_item_t fixed_out;
        s_valid = 1'b0;
        s_item  = '0;
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < $size(dir_rows); r++) begin
            it.operation        = dir_rows[r].operation;
            it.key              = dir_rows[r].key;
            it.key_high         = dir_rows[r].key_high;
            it.amount           = dir_rows[r].amount;
            fixed_out.range_sum = dir_rows[r].sum;
            fixed_out.status    = dir_rows[r].status;
            // A repeated row runs with both sides never idling.
            no_idle = (dir_rows[r].reps > 1);
            repeat (dir_rows[r].reps) offer_item(it, dir_rows[r].typed_in, fixed_out);
        end
        no_idle = 1'b0;

        // A little way into the random traffic the receiver holds off for a long
        // stretch, so the block keeps its result and stops taking new transfers.
        hold_at_result = results_seen + 40;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                // Halfway through the sender goes quiet until every result is back.
                s_valid <= 1'b0;
                while (pending_outcomes.size() != 0) @(posedge aclk);
                @(negedge aclk);
            end
            offer_item(random_item(), 1'b0, fixed_out);
        end

        // Drain every outstanding result, then give the block one full item time to
        // show anything it should not send.
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (ITEM_LATENCY) @(posedge aclk);

        $display("Checked %0d results from %0d input transfers: directed corners, a short",
                 results_seen, items_sent);
        $display("back-to-back burst and %0d random items, ending with %0d stored entries.",
                 RANDOM_ITEMS, tbl_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Result side: draws a wait before each result, takes the one long hold-off when
    // its turn comes, and checks every result transfer against the oldest prediction.
    initial begin : result_sink
        int        gap;
        out_item_t want;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (results_seen == hold_at_result) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_outcomes.size() == 0) begin
                $error("result transfer with nothing pending: range_sum %0d, status %0d",
                       m_item.range_sum, m_item.status);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (m_item.range_sum !== want.range_sum) begin
                    $error("range_sum: expected %0d, actual %0d",
                           want.range_sum, m_item.range_sum);
                    error_count++;
                end
                if (m_item.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_item.status);
                    error_count++;
                end
            end
            results_seen++;
        end
    end

    // Watchdog: ends the run when no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule

@@ filelist.f @@
rtl/skrs_pkg.sv
rtl/skrs_sat_add.sv
rtl/skrs_store.sv
rtl/sorted_key_range_sum_table_core.sv
dv/tb.sv
